FILE: sv/psp_pkg.sv
// ============================================================================
// psp_pkg
// Shared types and constants of the power-supply protection sequencer.
// ============================================================================
`default_nettype none

package psp_pkg;

    // Number of monitor channels that have a diagnostic word on the input.
    localparam int unsigned NUM_DIAG = 4;

    // Command codes
    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_FAST_TRIP = 2'd1,
        CMD_POWER_REQ = 2'd2,
        CMD_CLEAR     = 2'd3
    } command_t;

    // Fault codes
    localparam logic [2:0] FC_NONE      = 3'd0;
    localparam logic [2:0] FC_OVERCUR   = 3'd1;
    localparam logic [2:0] FC_OVERVOLT  = 3'd2;
    localparam logic [2:0] FC_OVERTEMP  = 3'd3;
    localparam logic [2:0] FC_UNDERVOLT = 3'd4;
    localparam logic [2:0] FC_CONV      = 3'd5;
    localparam logic [2:0] FC_BUS       = 3'd6;

    // Diagnostic bit masks
    localparam logic [15:0] BIT_POL    = 16'h0004;
    localparam logic [15:0] BIT_BUSUL  = 16'h0008;
    localparam logic [15:0] BIT_BUSOL  = 16'h0010;
    localparam logic [15:0] BIT_SHNTUL = 16'h0020;
    localparam logic [15:0] BIT_SHNTOL = 16'h0040;
    localparam logic [15:0] BIT_TMPOL  = 16'h0080;

    // Trip counter saturation value
    localparam logic [7:0] TRIPS_MAX = 8'd255;

    // Configuration register indexes
    localparam logic [2:0] REG_BOOT_WAIT     = 3'd0;
    localparam logic [2:0] REG_OFF_MIN       = 3'd1;
    localparam logic [2:0] REG_ARM_WAIT      = 3'd2;
    localparam logic [2:0] REG_STABLE        = 3'd3;
    localparam logic [2:0] REG_SETTLE        = 3'd4;
    localparam logic [2:0] REG_LOCKOUT_TRIPS = 3'd5;
    localparam logic [2:0] REG_FAULT_BITS    = 3'd6;
    localparam logic [2:0] REG_TRIP_BUS_LOSS = 3'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [15:0] diag_ch0;
        logic [15:0] diag_ch1;
        logic [15:0] diag_ch2;
        logic [15:0] diag_ch3;
        logic [3:0]  fresh_mask;
        logic [3:0]  cfg_ok_mask;
        logic        converter_fault;
        logic        update_busy;
        logic        host_link_alive;
        logic        request_on;
    } cmd_word_t;

    typedef struct packed {
        logic        power_enable;
        logic [2:0]  seq_state;
        logic [2:0]  fault_code;
        logic [3:0]  trip_channels;
        logic [7:0]  trips;
        logic        clear_sticky;
        logic        request_accepted;
        logic        led_host_link;
        logic        led_stale;
        logic        led_bus_gone;
        logic        led_warning;
    } res_word_t;

    // Priority classification of the tripping diagnostic bits.
    function automatic logic [2:0] fault_class(input logic [15:0] d);
        logic [2:0] c;
        begin
            if ((d & (BIT_SHNTOL | BIT_SHNTUL)) != 16'd0)
            begin
                c = FC_OVERCUR;
            end
            else if ((d & BIT_POL) != 16'd0)
            begin
                c = FC_OVERCUR;
            end
            else if ((d & BIT_BUSOL) != 16'd0)
            begin
                c = FC_OVERVOLT;
            end
            else if ((d & BIT_TMPOL) != 16'd0)
            begin
                c = FC_OVERTEMP;
            end
            else if ((d & BIT_BUSUL) != 16'd0)
            begin
                c = FC_UNDERVOLT;
            end
            else
            begin
                c = FC_NONE;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/psp_if.sv
// ============================================================================
// psp_if
// Valid/ready channels carrying command words and result words.
// ============================================================================
`default_nettype none

interface psp_cmd_if;
    import psp_pkg::*;
    logic      valid;
    logic      ready;
    cmd_word_t word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface psp_res_if;
    import psp_pkg::*;
    logic      valid;
    logic      ready;
    res_word_t word;
    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

FILE: sv/psu_protection_state_machine.sv
// ============================================================================
// psu_protection_state_machine
// Power-supply protection sequencer: boot, off, arming, on, tripped, lockout.
// ============================================================================
// Flow: an accepted command word is held in the input register, then its
//   result word in the result register; an undrained result stalls it.
// Throughput: 1 word per cycle while the sink keeps up; the whole state
//   update is one combinational pass between the input and result registers.
// Reset: async active low; mode boot, all counters/codes/flags zero, power
//   off, configuration registers back to their defaults.
// ============================================================================
`default_nettype none

module psu_protection_state_machine
    import psp_pkg::*;
#(
    parameter int unsigned CHANNELS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    psp_cmd_if.sink          cmd,
    psp_res_if.source        res
);

    typedef enum logic [2:0] {
        M_BOOT    = 3'd0,
        M_OFF     = 3'd1,
        M_ARMING  = 3'd2,
        M_ON      = 3'd3,
        M_TRIPPED = 3'd4,
        M_LOCKOUT = 3'd5
    } mode_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] boot_wait_reg;
    logic [15:0] off_min_reg;
    logic [15:0] arm_wait_reg;
    logic [15:0] stable_reg;
    logic [15:0] settle_reg;
    logic [7:0]  lockout_trips_reg;
    logic [15:0] fault_bits_reg;
    logic        trip_bus_loss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_wait_reg     <= 16'd100;
            off_min_reg       <= 16'd100;
            arm_wait_reg      <= 16'd500;
            stable_reg        <= 16'd10000;
            settle_reg        <= 16'd50;
            lockout_trips_reg <= 8'd3;
            fault_bits_reg    <= 16'h00FC;
            trip_bus_loss_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOOT_WAIT:     boot_wait_reg     <= cfg_data;
                REG_OFF_MIN:       off_min_reg       <= cfg_data;
                REG_ARM_WAIT:      arm_wait_reg      <= cfg_data;
                REG_STABLE:        stable_reg        <= cfg_data;
                REG_SETTLE:        settle_reg        <= cfg_data;
                REG_LOCKOUT_TRIPS: lockout_trips_reg <= cfg_data[7:0];
                REG_FAULT_BITS:    fault_bits_reg    <= cfg_data;
                REG_TRIP_BUS_LOSS: trip_bus_loss_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Word flow: input register -> single-pass update -> result register.
    // Advance whenever the result register is empty or being drained, so
    // a new word enters every cycle while the sink keeps up.
    // ------------------------------------------------------------------
    logic      in_valid_reg;
    cmd_word_t in_word_reg;
    logic      out_valid_reg;
    res_word_t out_word_reg;
    logic      advance;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign res.valid = out_valid_reg;
    assign res.word  = out_word_reg;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    mode_t       mode_reg,        mode_next;
    logic [2:0]  code_reg,        code_next;
    logic [3:0]  trip_chan_reg,   trip_chan_next;
    logic [7:0]  trips_reg,       trips_next;
    logic [31:0] entry_time_reg,  entry_time_next;
    logic [31:0] trip_time_reg,   trip_time_next;
    logic        wants_on_reg,    wants_on_next;
    logic        pend_trip_reg,   pend_trip_next;
    logic        enable_reg,      enable_next;
    res_word_t   res_next;

    // Per-word channel evaluation
    logic [15:0] diag_w [NUM_DIAG];
    logic [15:0] act_mask;
    logic [15:0] fault_hits;
    logic [3:0]  fault_chans;
    logic [3:0]  alive;
    logic [3:0]  stale;
    logic [3:0]  cfg_bad;
    logic        stale_any;
    logic        bus_down;
    logic        conv_fault;
    logic [31:0] now;
    logic        clr;

    assign now       = in_word_reg.now_ms;
    assign diag_w[0] = in_word_reg.diag_ch0;
    assign diag_w[1] = in_word_reg.diag_ch1;
    assign diag_w[2] = in_word_reg.diag_ch2;
    assign diag_w[3] = in_word_reg.diag_ch3;

    // Bus under-limit only counts as a fault while on.
    assign act_mask = (mode_reg == M_ON) ? fault_bits_reg : (fault_bits_reg & ~BIT_BUSUL);

    always_comb
    begin
        fault_hits  = 16'd0;
        fault_chans = 4'd0;
        alive       = 4'd0;
        stale       = 4'd0;
        cfg_bad     = 4'd0;
        for (int i = 0; i < NUM_DIAG; i++)
        begin
            if (i < CHANNELS)
            begin
                fault_hits     = fault_hits | (diag_w[i] & act_mask);
                fault_chans[i] = |(diag_w[i] & act_mask);
                alive[i]       = in_word_reg.fresh_mask[i];
                stale[i]       = !in_word_reg.fresh_mask[i];
                cfg_bad[i]     = in_word_reg.fresh_mask[i] && !in_word_reg.cfg_ok_mask[i];
            end
        end
    end

    // Channels without a diagnostic input are absent and so always stale.
    assign stale_any  = (|stale) || (CHANNELS > NUM_DIAG);
    assign bus_down   = (alive == 4'd0);
    assign conv_fault = in_word_reg.converter_fault
                        && (mode_reg == M_ON || mode_reg == M_ARMING);

    // ------------------------------------------------------------------
    // Next-state logic, evaluated in program order like the firmware loop.
    // Each mode change restamps the entry time only if the mode differs.
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next       = mode_reg;
        code_next       = code_reg;
        trip_chan_next  = trip_chan_reg;
        trips_next      = trips_reg;
        entry_time_next = entry_time_reg;
        trip_time_next  = trip_time_reg;
        wants_on_next   = wants_on_reg;
        pend_trip_next  = pend_trip_reg;
        enable_next     = enable_reg;
        clr             = 1'b0;
        res_next        = '0;
        res_next.request_accepted = 1'b1;

        unique case (command_t'(in_word_reg.command))
            CMD_TICK:
            begin
                // Deferred fast trip lands first.
                if (pend_trip_reg)
                begin
                    pend_trip_next = 1'b0;
                    if (mode_reg == M_ON || mode_reg == M_ARMING)
                    begin
                        code_next      = FC_NONE;
                        trip_chan_next = 4'd0;
                        trip_time_next = now;
                        if (trips_next != TRIPS_MAX)
                        begin
                            trips_next = trips_next + 8'd1;
                        end
                        mode_next       = M_TRIPPED;
                        entry_time_next = now;
                    end
                end

                unique case (mode_next)
                    M_BOOT:
                    begin
                        enable_next = 1'b0;
                        if ((now - entry_time_next) >= {16'd0, boot_wait_reg})
                        begin
                            clr             = 1'b1;
                            mode_next       = M_OFF;
                            entry_time_next = now;
                        end
                    end
                    M_OFF:
                    begin
                        enable_next = 1'b0;
                        if (wants_on_reg && (now - entry_time_next) >= {16'd0, off_min_reg})
                        begin
                            clr             = 1'b1;
                            enable_next     = 1'b1;
                            mode_next       = M_ARMING;
                            entry_time_next = now;
                        end
                    end
                    M_ARMING:
                    begin
                        if (!wants_on_reg)
                        begin
                            enable_next     = 1'b0;
                            mode_next       = M_OFF;
                            entry_time_next = now;
                        end
                        else if (conv_fault)
                        begin
                            enable_next    = 1'b0;
                            code_next      = FC_CONV;
                            trip_chan_next = 4'd0;
                            trip_time_next = now;
                            if (trips_next != TRIPS_MAX)
                            begin
                                trips_next = trips_next + 8'd1;
                            end
                            mode_next       = M_TRIPPED;
                            entry_time_next = now;
                        end
                        else if ((now - entry_time_next) >= {16'd0, arm_wait_reg})
                        begin
                            clr             = 1'b1;
                            mode_next       = M_ON;
                            entry_time_next = now;
                        end
                    end
                    M_ON:
                    begin
                        if (!wants_on_reg)
                        begin
                            enable_next     = 1'b0;
                            mode_next       = M_OFF;
                            entry_time_next = now;
                        end
                        else
                        begin
                            // Long stable run forgives earlier trips.
                            if ((now - entry_time_next) >= {16'd0, stable_reg})
                            begin
                                trips_next = 8'd0;
                            end
                            if (fault_hits != 16'd0 || conv_fault
                                || (trip_bus_loss_reg && bus_down))
                            begin
                                enable_next    = 1'b0;
                                trip_chan_next = fault_chans;
                                if (conv_fault)
                                begin
                                    code_next = FC_CONV;
                                end
                                else if (fault_hits != 16'd0)
                                begin
                                    code_next = fault_class(fault_hits);
                                end
                                else
                                begin
                                    code_next = FC_BUS;
                                end
                                trip_time_next = now;
                                if (trips_next != TRIPS_MAX)
                                begin
                                    trips_next = trips_next + 8'd1;
                                end
                                mode_next       = M_TRIPPED;
                                entry_time_next = now;
                            end
                        end
                    end
                    M_TRIPPED:
                    begin
                        enable_next = 1'b0;
                        // Classify an unexplained trip once things settle.
                        if (code_next == FC_NONE
                            && (now - trip_time_next) >= {16'd0, settle_reg})
                        begin
                            if (fault_hits != 16'd0)
                            begin
                                code_next      = fault_class(fault_hits);
                                trip_chan_next = fault_chans;
                            end
                            else if (conv_fault)
                            begin
                                code_next = FC_CONV;
                            end
                            else
                            begin
                                code_next = FC_BUS;
                            end
                        end
                        if (trips_next >= lockout_trips_reg)
                        begin
                            mode_next       = M_LOCKOUT;
                            entry_time_next = now;
                        end
                    end
                    M_LOCKOUT:
                    begin
                        enable_next = 1'b0;
                    end
                    default:
                    begin
                        mode_next       = M_BOOT;
                        entry_time_next = now;
                    end
                endcase

                res_next.clear_sticky  = clr;
                res_next.led_host_link = in_word_reg.host_link_alive;
                res_next.led_stale     = stale_any;
                res_next.led_bus_gone  = bus_down;
                res_next.led_warning   = (cfg_bad != 4'd0) || conv_fault
                                         || (fault_hits != 16'd0 && mode_next != M_TRIPPED);
            end
            CMD_FAST_TRIP:
            begin
                // Drop power now; the trip itself lands on the next tick.
                if (mode_reg == M_ON || mode_reg == M_ARMING)
                begin
                    enable_next    = 1'b0;
                    pend_trip_next = 1'b1;
                end
            end
            CMD_POWER_REQ:
            begin
                if (in_word_reg.request_on
                    && (mode_reg == M_TRIPPED || mode_reg == M_LOCKOUT))
                begin
                    res_next.request_accepted = 1'b0;
                end
                else if (in_word_reg.request_on && in_word_reg.update_busy)
                begin
                    res_next.request_accepted = 1'b0;
                end
                else
                begin
                    wants_on_next = in_word_reg.request_on;
                end
            end
            CMD_CLEAR:
            begin
                // Lockout keeps its mode until reset.
                res_next.clear_sticky = 1'b1;
                code_next             = FC_NONE;
                trip_chan_next        = 4'd0;
                wants_on_next         = 1'b0;
                if (mode_reg == M_TRIPPED)
                begin
                    trips_next      = 8'd0;
                    mode_next       = M_OFF;
                    entry_time_next = now;
                end
            end
            default:
            begin
            end
        endcase

        res_next.power_enable  = enable_next;
        res_next.seq_state     = mode_next;
        res_next.fault_code    = code_next;
        res_next.trip_channels = trip_chan_next;
        res_next.trips         = trips_next;
    end

    // ------------------------------------------------------------------
    // Control, state and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= M_BOOT;
            code_reg       <= FC_NONE;
            trip_chan_reg  <= 4'd0;
            trips_reg      <= 8'd0;
            entry_time_reg <= 32'd0;
            trip_time_reg  <= 32'd0;
            wants_on_reg   <= 1'b0;
            pend_trip_reg  <= 1'b0;
            enable_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_next;
                code_reg       <= code_next;
                trip_chan_reg  <= trip_chan_next;
                trips_reg      <= trips_next;
                entry_time_reg <= entry_time_next;
                trip_time_reg  <= trip_time_next;
                wants_on_reg   <= wants_on_next;
                pend_trip_reg  <= pend_trip_next;
                enable_reg     <= enable_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_word_reg <= cmd.word;
        end
        if (advance)
        begin
            out_word_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
